[src/clsr_pkg.sv]
// shared types and constants of the combined lcg shuffle generator
// used by clsr_ctrl, clsr_datapath and the top level; no dependencies
`default_nettype none

package clsr_pkg;

   localparam int DEF_TABLE_SIZE = 32;

   localparam logic [31:0] MOD1        = 32'd2147483563;
   localparam logic [31:0] MOD2        = 32'd2147483399;
   localparam logic [15:0] MUL1        = 16'd40014;
   localparam logic [15:0] MUL2        = 16'd40692;
   // 2^31 mod MOD1 and 2^31 mod MOD2
   localparam logic [8:0]  FOLD1       = 9'd85;
   localparam logic [8:0]  FOLD2       = 9'd249;
   localparam logic [30:0] RAW_MAX     = 31'd2147483562;
   localparam logic [30:0] SECOND_INIT = 31'd123456789;

   typedef struct packed {
      logic signed [31:0] low_bound;
      logic signed [31:0] high_bound;
   } req_word_type;

   typedef struct packed {
      logic [30:0]        raw_value;
      logic signed [31:0] scaled_value;
      logic               bad_range;
   } rsp_word_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_BAD,
      ST_WSEED,
      ST_WMUL,
      ST_WRED,
      ST_WIDX,
      ST_WFIX,
      ST_MUL,
      ST_RED,
      ST_MIX,
      ST_PROD,
      ST_SUM,
      ST_DIV1,
      ST_DIV2,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic load_req;
      logic seed_load;
      logic mul;
      logic red1;
      logic red2;
      logic warm_wr;
      logic mix;
      logic prod;
      logic idx_mul;
      logic sum;
      logic idx_fix;
      logic div1;
      logic div2;
      logic out_load;
      logic out_bad;
   } cmd_type;

   typedef struct packed {
      logic bad_range;
      logic cnt_zero;
   } status_type;

endpackage

`default_nettype wire

[src/clsr_ctrl.sv]
// sequencer of the combined lcg shuffle generator: state machine, warm flag, result valid
// depends on clsr_pkg; drives the command word of clsr_datapath
`default_nettype none

module clsr_ctrl (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  wire                     rsp_ready,
   input  wire                     csr_write_enable,
   input  clsr_pkg::status_type    status,
   output clsr_pkg::cmd_type       cmd
);
   import clsr_pkg::*;

   state_type state_ff, state_in;
   logic      warm_ff;
   logic      rsp_valid_ff;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req_valid) state_in = ST_CHECK;
         ST_CHECK: begin
            if (status.bad_range) state_in = ST_BAD;
            else if (!warm_ff)    state_in = ST_WSEED;
            else                  state_in = ST_MUL;
         end
         ST_BAD:   if (slot_free) state_in = ST_IDLE;
         ST_WSEED: state_in = ST_WMUL;
         ST_WMUL:  state_in = ST_WRED;
         ST_WRED:  state_in = status.cnt_zero ? ST_WIDX : ST_WMUL;
         ST_WIDX:  state_in = ST_WFIX;
         ST_WFIX:  state_in = ST_MUL;
         ST_MUL:   state_in = ST_RED;
         ST_RED:   state_in = ST_MIX;
         ST_MIX:   state_in = ST_PROD;
         ST_PROD:  state_in = ST_SUM;
         ST_SUM:   state_in = ST_DIV1;
         ST_DIV1:  state_in = ST_DIV2;
         ST_DIV2:  state_in = ST_OUT;
         ST_OUT:   if (slot_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_IDLE:  cmd.load_req = req_valid;
         ST_BAD:   cmd.out_bad = slot_free;
         ST_WSEED: cmd.seed_load = 1'b1;
         ST_WMUL:  cmd.mul = 1'b1;
         ST_WRED: begin
            cmd.red1    = 1'b1;
            cmd.warm_wr = 1'b1;
         end
         ST_WIDX:  cmd.idx_mul = 1'b1;
         ST_WFIX:  cmd.idx_fix = 1'b1;
         ST_MUL:   cmd.mul = 1'b1;
         ST_RED: begin
            cmd.red1 = 1'b1;
            cmd.red2 = 1'b1;
         end
         ST_MIX:   cmd.mix = 1'b1;
         ST_PROD: begin
            cmd.prod    = 1'b1;
            cmd.idx_mul = 1'b1;
         end
         ST_SUM: begin
            cmd.sum     = 1'b1;
            cmd.idx_fix = 1'b1;
         end
         ST_DIV1:  cmd.div1 = 1'b1;
         ST_DIV2:  cmd.div2 = 1'b1;
         ST_OUT:   cmd.out_load = slot_free;
         default:  cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         warm_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_write_enable)         warm_ff <= 1'b0;
         else if (state_ff == ST_WFIX) warm_ff <= 1'b1;
         if (cmd.out_load || cmd.out_bad) rsp_valid_ff <= 1'b1;
         else if (rsp_ready)              rsp_valid_ff <= 1'b0;
      end
   end

endmodule

`default_nettype wire

[src/clsr_datapath.sv]
// datapath of the combined lcg shuffle generator: both lcgs, shuffle memory,
// bucket index, interval scaling and result word; depends on clsr_pkg
`default_nettype none

module clsr_datapath #(
   parameter int TABLE_SIZE = clsr_pkg::DEF_TABLE_SIZE
) (
   input  wire                     clock,
   input  wire                     reset,
   input  clsr_pkg::req_word_type  req_word,
   input  wire                     csr_write_enable,
   input  wire [30:0]              csr_write_data,
   input  clsr_pkg::cmd_type       cmd,
   output clsr_pkg::status_type    status,
   output clsr_pkg::rsp_word_type  rsp_word
);
   import clsr_pkg::*;

   localparam int     IDX_W     = $clog2(TABLE_SIZE);
   localparam int     CNT_W     = $clog2(TABLE_SIZE + 8);
   localparam int     Q_W       = IDX_W + 1;
   localparam int     IDX_SHIFT = 40;
   localparam int     RECIP_W   = IDX_W + 10;
   localparam int     RP_W      = 31 + RECIP_W;
   localparam longint BUCKET    = 1 + longint'(RAW_MAX) / TABLE_SIZE;
   localparam longint RECIP     = (longint'(1) << IDX_SHIFT) / BUCKET;

   // (x * mul) mod m from the 47-bit product, folding the top bits by 2^31 mod m
   function automatic logic [30:0] lcg_fold(input logic [46:0] p, input logic [31:0] m,
                                            input logic [8:0] f);
      logic [31:0] s;
      s = 32'(p[46:31]) * 32'(f) + 32'(p[30:0]);
      if (s >= m) s = s - m;
      return s[30:0];
   endfunction

   logic [30:0]          seed_ff;
   logic [30:0]          seed_eff;
   logic [30:0]          x1_ff, x2_ff, x1_in, x2_in;
   logic [46:0]          p1_ff, p2_ff;
   logic [30:0]          rd_ff;
   logic [30:0]          last_ff, last_in;
   logic [31:0]          diff;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [CNT_W-1:0]     cnt_ff;
   logic signed [31:0]   lo_ff, hi_ff;
   logic [32:0]          span_ff;
   logic [46:0]          pl_ff;
   logic [47:0]          ph_ff;
   logic [RP_W-1:0]      rp_ff;
   logic [63:0]          prod_ff;
   logic [32:0]          qh_ff;
   logic [40:0]          r_ff;
   logic [32:0]          q_ff;
   logic [9:0]           r_hi;
   logic [31:0]          r_fold;
   logic [Q_W-1:0]       q_est;
   logic [Q_W:0]         q_cor;
   logic [39:0]          thr;
   logic                 wr_en;
   logic [IDX_W-1:0]     wr_addr;
   logic [30:0]          wr_data;
   rsp_word_type         rsp_ff;
   logic [30:0]          shuf_mem [TABLE_SIZE];

   assign seed_eff = (seed_ff == 31'd0) ? 31'd1 : (seed_ff > RAW_MAX) ? RAW_MAX : seed_ff;
   assign x1_in    = lcg_fold(p1_ff, MOD1, FOLD1);
   assign x2_in    = lcg_fold(p2_ff, MOD2, FOLD2);

   always_comb begin
      diff = {1'b0, rd_ff} - {1'b0, x2_ff};
      if ($signed(diff) < 32'sd1) diff = diff + {1'b0, RAW_MAX};
      last_in = diff[30:0];
   end

   // reciprocal estimate is low by at most one bucket
   always_comb begin
      q_est = rp_ff[IDX_SHIFT +: Q_W];
      thr   = (40'(q_est) + 40'd1) * 40'(BUCKET);
      q_cor = (Q_W+1)'(q_est) + (Q_W+1)'({9'd0, last_ff} >= thr);
      if (q_cor >= (Q_W+1)'(TABLE_SIZE)) q_cor = (Q_W+1)'(TABLE_SIZE - 1);
      idx_in = q_cor[IDX_W-1:0];
   end

   assign r_hi   = r_ff[40:31];
   assign r_fold = 32'(r_hi) * 32'(FOLD1) + 32'(r_ff[30:0]);

   assign wr_en   = (cmd.warm_wr && (cnt_ff < CNT_W'(TABLE_SIZE))) || cmd.mix;
   assign wr_addr = cmd.mix ? idx_ff : cnt_ff[IDX_W-1:0];
   assign wr_data = cmd.mix ? x1_ff : x1_in;

   always_ff @(posedge clock) begin
      if (wr_en) shuf_mem[wr_addr] <= wr_data;
      if (cmd.mul) rd_ff <= shuf_mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= 31'd1;
         x1_ff   <= 31'd1;
         x2_ff   <= SECOND_INIT;
         last_ff <= '0;
         idx_ff  <= '0;
      end else begin
         if (csr_write_enable) seed_ff <= csr_write_data;
         if (cmd.seed_load) x1_ff <= seed_eff;
         else if (cmd.red1) x1_ff <= x1_in;
         if (cmd.seed_load) x2_ff <= seed_eff;
         else if (cmd.red2) x2_ff <= x2_in;
         // warm-up ends with the bottom entry, which becomes the last word
         if (cmd.warm_wr && (cnt_ff == '0)) last_ff <= x1_in;
         else if (cmd.mix)                  last_ff <= last_in;
         if (cmd.idx_fix) idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         lo_ff <= req_word.low_bound;
         hi_ff <= req_word.high_bound;
      end
      span_ff <= {hi_ff[31], hi_ff} - {lo_ff[31], lo_ff} + 33'd1;
      if (cmd.seed_load) cnt_ff <= CNT_W'(TABLE_SIZE + 7);
      else if (cmd.warm_wr) cnt_ff <= cnt_ff - CNT_W'(1);
      if (cmd.mul) begin
         p1_ff <= 47'(x1_ff) * 47'(MUL1);
         p2_ff <= 47'(x2_ff) * 47'(MUL2);
      end
      if (cmd.prod) begin
         pl_ff <= 47'(last_ff) * 47'(span_ff[15:0]);
         ph_ff <= 48'(last_ff) * 48'(span_ff[32:16]);
      end
      if (cmd.idx_mul) rp_ff <= RP_W'(last_ff) * RP_W'(RECIP);
      if (cmd.sum) prod_ff <= {ph_ff, 16'd0} + 64'(pl_ff);
      // floor(prod / MOD1) by folding 2^31 = MOD1 + FOLD1 twice
      if (cmd.div1) begin
         qh_ff <= prod_ff[63:31];
         r_ff  <= 41'(prod_ff[63:31]) * 41'(FOLD1) + 41'(prod_ff[30:0]);
      end
      if (cmd.div2) q_ff <= qh_ff + 33'(r_hi) + 33'(r_fold >= MOD1);
      if (cmd.out_load) begin
         rsp_ff.raw_value    <= last_ff;
         rsp_ff.scaled_value <= lo_ff + $signed(q_ff[31:0]);
         rsp_ff.bad_range    <= 1'b0;
      end else if (cmd.out_bad) begin
         rsp_ff.raw_value    <= '0;
         rsp_ff.scaled_value <= '0;
         rsp_ff.bad_range    <= 1'b1;
      end
   end

   assign status.bad_range = (hi_ff < lo_ff);
   assign status.cnt_zero  = (cnt_ff == '0);
   assign rsp_word         = rsp_ff;

endmodule

`default_nettype wire

[src/combined_lcg_shuffle_rng_unit.sv]
// combined lcg shuffle generator, top level: sequencer plus datapath
// depends on clsr_pkg, clsr_ctrl and clsr_datapath
//
// each request word carries an inclusive interval; each response word returns the
// shuffled raw draw in 1..2147483562 and low + floor(raw * span / 2147483563).
// when high is below low the response is zero with bad_range set and no draw is made.
// a request is taken only while the sequencer is idle; a waiting response does not
// block it, and the sequencer holds in its last step while the receiver stalls.
// a warm draw runs the sequencer through both lcg multipliers, the shuffle memory read
// and write, the bucket index and the scaling multiply and fold one after another.
// a bad interval skips the draw and answers straight after the range check.
// the first draw after reset or a seed write first runs the warm-up of
// TABLE_SIZE + 8 lcg steps.
// a seed write via csr_write_enable takes effect at once and is meant for idle time.
// reset (synchronous) restores seed 1, clears rsp_valid and marks the block cold.
`default_nettype none

module combined_lcg_shuffle_rng_unit #(
   parameter int TABLE_SIZE = clsr_pkg::DEF_TABLE_SIZE
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   output logic                    req_ready,
   input  clsr_pkg::req_word_type  req_word,
   output logic                    rsp_valid,
   input  wire                     rsp_ready,
   output clsr_pkg::rsp_word_type  rsp_word,
   input  wire                     csr_write_enable,
   input  wire [30:0]              csr_write_data
);
   import clsr_pkg::*;

   cmd_type    cmd;
   status_type status;

   clsr_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .csr_write_enable (csr_write_enable),
      .status           (status),
      .cmd              (cmd)
   );

   clsr_datapath #(
      .TABLE_SIZE (TABLE_SIZE)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_word         (req_word),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .cmd              (cmd),
      .status           (status),
      .rsp_word         (rsp_word)
   );

endmodule

`default_nettype wire

[verif/clsr_rng_checker.sv]
// checker for the combined lcg shuffle generator: watches the request, response and csr ports,
// predicts each response word and compares it field by field
// depends on clsr_pkg
`timescale 1ns / 100ps

module clsr_rng_checker (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   input  wire                    req_ready,
   input  clsr_pkg::req_word_type req_word,
   input  wire                    rsp_valid,
   input  wire                    rsp_ready,
   input  clsr_pkg::rsp_word_type rsp_word,
   input  wire                    csr_write_enable,
   input  wire [30:0]             csr_write_data,
   output int                     mismatch_count,
   output int                     draws_in_flight
);
   import clsr_pkg::*;

   localparam int     TABLE_SLOTS  = DEF_TABLE_SIZE;
   localparam longint RAW_TOP      = longint'(RAW_MAX);
   localparam longint BUCKET_WIDTH = 1 + RAW_TOP / TABLE_SLOTS;

   logic [30:0]  seed_reg;
   longint       lcg_a;
   longint       lcg_b;
   longint       prev_raw;
   longint       shuffle [TABLE_SLOTS];
   bit           warm;
   rsp_word_type draw_queue [$];
   rsp_word_type oldest;

   function automatic longint lcg_step(longint x, longint mul, longint modulus);
      return (x * mul) % modulus;
   endfunction

   // reseed both generators and fill the table from the top slot down
   function automatic void load_table();
      longint s;
      s = longint'(seed_reg);
      if (s < 1) s = 1;
      if (s > RAW_TOP) s = RAW_TOP;
      lcg_a = s;
      lcg_b = s;
      for (int i = TABLE_SLOTS + 7; i >= 0; i--) begin
         lcg_a = lcg_step(lcg_a, MUL1, MOD1);
         if (i < TABLE_SLOTS) shuffle[i] = lcg_a;
      end
      prev_raw = shuffle[0];
      warm = 1'b1;
   endfunction

   function automatic longint next_raw();
      int slot;
      if (!warm) load_table();
      lcg_a = lcg_step(lcg_a, MUL1, MOD1);
      lcg_b = lcg_step(lcg_b, MUL2, MOD2);
      slot = int'(prev_raw / BUCKET_WIDTH);
      if (slot < 0) slot = 0;
      if (slot >= TABLE_SLOTS) slot = TABLE_SLOTS - 1;
      prev_raw = shuffle[slot] - lcg_b;
      shuffle[slot] = lcg_a;
      if (prev_raw < 1) prev_raw += RAW_TOP;
      return prev_raw;
   endfunction

   function automatic rsp_word_type scale_draw(req_word_type w);
      longint       lo;
      longint       hi;
      longint       raw;
      longint       offset;
      rsp_word_type r;
      lo = w.low_bound;
      hi = w.high_bound;
      r = '0;
      // inverted interval: no draw, state untouched
      if (hi < lo) begin
         r.bad_range = 1'b1;
         return r;
      end
      raw = next_raw();
      offset = (raw * (hi - lo + 1)) / longint'(MOD1);
      r.raw_value = raw[30:0];
      r.scaled_value = lo[31:0] + offset[31:0];
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         seed_reg = 31'd1;
         lcg_a = 1;
         lcg_b = longint'(SECOND_INIT);
         prev_raw = 0;
         foreach (shuffle[i]) shuffle[i] = 0;
         warm = 1'b0;
         draw_queue.delete();
         draws_in_flight <= 0;
      end else begin
         if (csr_write_enable) begin
            seed_reg = csr_write_data;
            warm = 1'b0;
         end
         if (rsp_valid && rsp_ready) begin
            if (draw_queue.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: unexpected word: raw %0d scaled %0d bad %0b", $realtime,
                           rsp_word.raw_value, rsp_word.scaled_value, rsp_word.bad_range);
            end else begin
               oldest = draw_queue.pop_front();
               if (rsp_word.raw_value !== oldest.raw_value ||
                   rsp_word.scaled_value !== oldest.scaled_value ||
                   rsp_word.bad_range !== oldest.bad_range) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display({"%0t: mismatch: raw exp %0d got %0d, scaled exp %0d got %0d,",
                               " bad exp %0b got %0b"}, $realtime,
                              oldest.raw_value, rsp_word.raw_value,
                              oldest.scaled_value, rsp_word.scaled_value,
                              oldest.bad_range, rsp_word.bad_range);
               end
            end
         end
         if (req_valid && req_ready) draw_queue.push_back(scale_draw(req_word));
         draws_in_flight <= draw_queue.size();
      end
   end

endmodule

[verif/tb_combined_lcg_shuffle_rng_unit.sv]
// testbench top for combined_lcg_shuffle_rng_unit: clock, reset, request and seed stimulus,
// random response stalls and the final verdict
// depends on clsr_pkg, the unit under test and clsr_rng_checker
`timescale 1ns / 100ps

module tb_combined_lcg_shuffle_rng_unit;
   import clsr_pkg::*;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_word_type req_word = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_word_type rsp_word;
   logic         csr_write_enable = 1'b0;
   logic [30:0]  csr_write_data = '0;
   bit           calm = 1'b0;
   int           stall_left = 0;
   int           mismatch_count;
   int           draws_in_flight;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   combined_lcg_shuffle_rng_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_word         (req_word),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_word         (rsp_word),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   clsr_rng_checker checker_i (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_word         (req_word),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_word         (rsp_word),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .mismatch_count   (mismatch_count),
      .draws_in_flight  (draws_in_flight)
   );

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   function automatic req_word_type random_interval();
      req_word_type       w;
      longint             top;
      logic signed [31:0] a;
      logic signed [31:0] b;
      a = $urandom();
      b = $urandom();
      w.low_bound = a;
      w.high_bound = b;
      case ($urandom_range(0, 9))
         2, 3, 4: begin
            top = longint'(a) + longint'($urandom_range(0, 255));
            if (top > 64'sd2147483647) top = 64'sd2147483647;
            w.high_bound = top[31:0];
         end
         5: w.high_bound = a;
         6: begin
            w.low_bound = (a > b) ? a : b;
            w.high_bound = (a > b) ? b : a;
         end
         7: begin
            w.low_bound = 32'sh80000000 + $urandom_range(0, 1023);
            w.high_bound = 32'sh7FFFFFFF - $urandom_range(0, 1023);
         end
         8: begin
            w.low_bound = {1'b1, a[30:0]};
            w.high_bound = {1'b0, b[30:0]};
         end
         9: begin
            w.low_bound = $urandom_range(0, 20) - 10;
            w.high_bound = w.low_bound + $urandom_range(0, 20);
         end
         default: ;  // independent bounds, about half of them inverted
      endcase
      return w;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_ready <= 1'b1;
         if (!calm && ((rsp_valid && rsp_ready && $urandom_range(0, 1) == 0) ||
                       $urandom_range(0, 15) == 0))
            stall_left <= pick_gap();
      end
   end

   // valid stays high across back-to-back words; it only drops for a gap, a seed write or the end
   task automatic send_word(input req_word_type w);
      int gap;
      gap = (calm || $urandom_range(0, 1) == 0) ? 0 : pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_bounds(input logic signed [31:0] lo, input logic signed [31:0] hi);
      req_word_type w;
      w.low_bound = lo;
      w.high_bound = hi;
      send_word(w);
   endtask

   task automatic write_seed(input logic [30:0] value);
      req_valid <= 1'b0;
      do @(posedge clock); while (draws_in_flight != 0);
      repeat (12) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   initial begin
      logic [30:0] seed_value;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // inverted interval while cold must not run the warm-up
      send_bounds(32'sh7FFFFFFF, 32'sh80000000);
      send_bounds(0, 0);
      send_bounds(32'sh80000000, 32'sh7FFFFFFF);  // full 32-bit span
      send_bounds(32'sh80000000, 32'sh80000000);
      send_bounds(32'sh7FFFFFFF, 32'sh7FFFFFFF);
      send_bounds(1, 0);
      send_bounds(0, -1);
      send_bounds(-1, 0);
      send_bounds(-1, -1);
      send_bounds(32'sh80000000, -1);
      send_bounds(0, 32'sh7FFFFFFF);
      send_bounds(32'sh7FFFFFFE, 32'sh7FFFFFFF);
      send_bounds(32'sh80000000, 32'sh80000001);
      send_bounds(-5, 5);
      send_bounds(0, 2147483562);  // span equals the first modulus
      send_bounds(1, 2147483563);
      send_bounds(32'sh80000000, 0);
      send_bounds(-1, 32'sh7FFFFFFF);
      send_bounds(32'shAAAAAAAA, 32'sh55555555);
      send_bounds(32'sh55555555, 32'shAAAAAAAA);
      send_bounds(32'sh7FFFFFFF, 32'sh80000000);
      send_bounds(0, 1);

      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: seed_value = RAW_MAX;
            1: seed_value = '0;             // acts as 1
            2: seed_value = '1;             // saturates
            3: seed_value = RAW_MAX + 31'd1;
            4: seed_value = 31'd1;
            default: seed_value = 31'($urandom());
         endcase
         write_seed(seed_value);
         calm <= (phase % 3 == 2);
         repeat (229) send_word(random_interval());
      end

      req_valid <= 1'b0;
      do @(posedge clock); while (draws_in_flight != 0);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb_combined_lcg_shuffle_rng_unit: done, clean");
      end else begin
         $display("tb_combined_lcg_shuffle_rng_unit: done, errors");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("tb_combined_lcg_shuffle_rng_unit: done, errors");
      $finish;
   end

endmodule
